// File: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FFBA_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FFBA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/ffba_pkg.sv
`default_nettype none

package ffba_pkg;

    // Default arena geometry (64 KiB arena)
    localparam int ARENA_BYTES_DEF   = 64 * 1024;
    localparam int HEADER_BYTES_DEF  = 24;
    localparam int GRANULE_BYTES_DEF = 8;

    // Default header memory geometry for the arena above
    localparam int HDR_DEPTH_DEF  = 8192;
    localparam int HDR_ADDR_W_DEF = 13;
    localparam int SIZE_W_DEF     = 16;

    // Fixed field widths of the request and response channels
    localparam int REQ_W     = 17;
    localparam int OFFSET_W  = 16;
    localparam int STATUS_W  = 2;

    typedef enum logic {
        FUNC_ALLOC = 1'b0,
        FUNC_FREE  = 1'b1
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_ALLOC_OK   = 2'd0,
        STATUS_ALLOC_FAIL = 2'd1,
        STATUS_FREED      = 2'd2,
        STATUS_NOT_FOUND  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_RECIP,
        FSM_ROUND,
        FSM_WALK,
        FSM_PEEK,
        FSM_MERGE,
        FSM_SPLIT,
        FSM_RESP
    } fsm_t;

    // Number of trailing zero bits of a positive constant
    function automatic int trailing_zeros(input int unsigned v);
        int  n;
        bit  done;
        n    = 0;
        done = 1'b0;
        for (int i = 0; i < 32; i++) begin
            if (!done && v[i]) begin
                n    = i;
                done = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/first_fit_block_allocator.sv
// First-fit block allocator with coalescing.
// Request channel (s_*): s_func selects allocate or free; s_req_size is the
// payload size for allocate, s_free_address the payload offset for free.
// Response channel (m_*): m_status and m_address, one response per request.
// Block headers live in a single-port-write, registered-read memory indexed
// by block start; a request walks the header chain one read per cycle.
// Allocate: reciprocal step, round-up step, header walk, a split write when
// the block is split, then the response; a size of 0 or one too large goes
// straight to the response.
// Free: header walk, then the response when the offset is not found; else a
// peek at the following block if one exists, the merge write, the response.
// One request is in flight at a time; a new one is accepted only in idle.
// After reset the arena is one free block; no initialization pass is needed.
// The response sits in an output register; a new request is accepted while it
// waits, and the finished one holds in the response state until m_ready frees
// the register.
`default_nettype none

module first_fit_block_allocator #(
    parameter int ARENA_BYTES   = ffba_pkg::ARENA_BYTES_DEF,
    parameter int HEADER_BYTES  = ffba_pkg::HEADER_BYTES_DEF,
    parameter int GRANULE_BYTES = ffba_pkg::GRANULE_BYTES_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_func,
    input  wire logic [ffba_pkg::REQ_W-1:0]    s_req_size,
    input  wire logic [ffba_pkg::OFFSET_W-1:0] s_free_address,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [ffba_pkg::STATUS_W-1:0]      m_status,
    output logic [ffba_pkg::OFFSET_W-1:0]      m_address
);

    import ffba_pkg::*;

    `include "assert_macros.svh"

    // Geometry
    localparam int SZ_W     = $clog2(ARENA_BYTES);
    localparam int POS_W    = SZ_W + 1;
    localparam int TZ_H     = trailing_zeros(HEADER_BYTES);
    localparam int TZ_G     = trailing_zeros(GRANULE_BYTES);
    localparam int ALIGN_SH = (TZ_H < TZ_G) ? TZ_H : TZ_G;
    localparam int DEPTH    = (ARENA_BYTES + (1 << ALIGN_SH) - 1) >> ALIGN_SH;
    localparam int ADDR_W   = $clog2(DEPTH);

    // Round-up by reciprocal multiply: exact for X_W-bit numerators
    localparam int X_W     = REQ_W + 1;
    localparam int RL      = $clog2(GRANULE_BYTES);
    localparam int RS      = X_W + RL;
    localparam int M_W     = RS + 1;
    localparam int PROD_W  = X_W + M_W;
    localparam logic [M_W-1:0] RECIP_C =
        M_W'(((64'd1 << RS) + GRANULE_BYTES - 1) / GRANULE_BYTES);

    // Working width for position and size arithmetic
    localparam int CW = ((POS_W > X_W) ? POS_W : X_W) + 2;
    localparam logic [CW-1:0] HDR_C   = CW'(HEADER_BYTES);
    localparam logic [CW-1:0] GRAN_C  = CW'(GRANULE_BYTES);
    localparam logic [CW-1:0] ARENA_C = CW'(ARENA_BYTES);
    localparam logic [CW-1:0] MAXREQ_C = CW'(ARENA_BYTES - HEADER_BYTES);

    function automatic logic [ADDR_W-1:0] to_index(input logic [CW-1:0] p);
        return p[ALIGN_SH +: ADDR_W];
    endfunction

    fsm_t                  state_reg, state_next;
    func_t                 func_reg, func_next;
    logic [OFFSET_W-1:0]   target_reg, target_next;
    logic [X_W-1:0]        x_reg, x_next;
    logic [X_W-1:0]        q_reg, q_next;
    logic [X_W-1:0]        need_reg, need_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [POS_W-1:0]      prev_pos_reg, prev_pos_next;
    logic [SZ_W-1:0]       prev_size_reg, prev_size_next;
    logic                  prev_free_reg, prev_free_next;
    logic                  prev_valid_reg, prev_valid_next;
    logic [SZ_W-1:0]       own_size_reg, own_size_next;
    logic [SZ_W-1:0]       succ_size_reg, succ_size_next;
    logic                  succ_free_reg, succ_free_next;
    logic [SZ_W-1:0]       rem_size_reg, rem_size_next;
    status_t               status_reg, status_next;
    logic [OFFSET_W-1:0]   addr_reg, addr_next;
    logic                  m_valid_reg, m_valid_next;
    status_t               m_status_reg, m_status_next;
    logic [OFFSET_W-1:0]   m_address_reg, m_address_next;

    logic                  mem_rd_en;
    logic [ADDR_W-1:0]     mem_rd_addr;
    logic [SZ_W-1:0]       mem_rd_size;
    logic                  mem_rd_free;
    logic                  mem_wr_en;
    logic [ADDR_W-1:0]     mem_wr_addr;
    logic [SZ_W-1:0]       mem_wr_size;
    logic                  mem_wr_free;

    logic [CW-1:0]         hdr_end;
    logic [CW-1:0]         pay_pos;
    logic [CW-1:0]         need_w;
    logic                  fits;
    logic                  split_ok;
    logic                  at_end;
    logic [PROD_W-1:0]     prod;
    logic [CW-1:0]         succ_add;
    logic [CW-1:0]         own_merged;
    logic [CW-1:0]         prev_merged;
    logic [CW-1:0]         rem_pos;
    logic                  req_bad;

    ffba_hdr_mem #(
        .DEPTH      (DEPTH),
        .ADDR_W     (ADDR_W),
        .SIZE_W     (SZ_W),
        .RESET_SIZE (ARENA_BYTES - HEADER_BYTES)
    ) u_hdr_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_size (mem_rd_size),
        .rd_free (mem_rd_free),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_size (mem_wr_size),
        .wr_free (mem_wr_free)
    );

    // Header walk arithmetic
    assign pay_pos  = CW'(pos_reg) + HDR_C;
    assign hdr_end  = pay_pos + CW'(mem_rd_size);
    assign need_w   = CW'(need_reg);
    assign fits     = mem_rd_free && (CW'(mem_rd_size) >= need_w);
    assign split_ok = CW'(mem_rd_size) >= (need_w + HDR_C + GRAN_C);
    assign at_end   = hdr_end >= ARENA_C;
    assign rem_pos  = pay_pos + need_w;
    assign req_bad  = (s_req_size == '0) || (CW'(s_req_size) > MAXREQ_C);

    // Round-up quotient
    assign prod = PROD_W'(x_reg) * PROD_W'(RECIP_C);

    // Coalesced sizes for a free
    assign succ_add    = succ_free_reg ? (HDR_C + CW'(succ_size_reg)) : '0;
    assign own_merged  = CW'(own_size_reg) + succ_add;
    assign prev_merged = CW'(prev_size_reg) + HDR_C + own_merged;

    assign s_ready   = (state_reg == FSM_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_status  = m_status_reg;
    assign m_address = m_address_reg;

    // Next state, memory commands and datapath updates
    always_comb begin
        state_next      = state_reg;
        func_next       = func_reg;
        target_next     = target_reg;
        x_next          = x_reg;
        q_next          = q_reg;
        need_next       = need_reg;
        pos_next        = pos_reg;
        prev_pos_next   = prev_pos_reg;
        prev_size_next  = prev_size_reg;
        prev_free_next  = prev_free_reg;
        prev_valid_next = prev_valid_reg;
        own_size_next   = own_size_reg;
        succ_size_next  = succ_size_reg;
        succ_free_next  = succ_free_reg;
        rem_size_next   = rem_size_reg;
        status_next     = status_reg;
        addr_next       = addr_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_address_next  = m_address_reg;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = '0;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = '0;
        mem_wr_size     = '0;
        mem_wr_free     = 1'b0;

        case (state_reg)
            FSM_IDLE: begin
                if (s_valid) begin
                    func_next       = func_t'(s_func);
                    target_next     = s_free_address;
                    x_next          = X_W'(s_req_size) + X_W'(GRANULE_BYTES - 1);
                    pos_next        = '0;
                    prev_valid_next = 1'b0;
                    addr_next       = '0;
                    if (func_t'(s_func) == FUNC_FREE) begin
                        mem_rd_en  = 1'b1;
                        state_next = FSM_WALK;
                    end else if (req_bad) begin
                        status_next = STATUS_ALLOC_FAIL;
                        state_next  = FSM_RESP;
                    end else begin
                        state_next = FSM_RECIP;
                    end
                end
            end

            FSM_RECIP: begin
                q_next     = prod[RS +: X_W];
                state_next = FSM_ROUND;
            end

            // Scale back to bytes and start the walk at the first block
            FSM_ROUND: begin
                need_next  = X_W'(CW'(q_reg) * GRAN_C);
                mem_rd_en  = 1'b1;
                state_next = FSM_WALK;
            end

            FSM_WALK: begin
                if (func_reg == FUNC_ALLOC) begin
                    if (fits) begin
                        // Claim the block, trimming it when the rest can stand alone
                        mem_wr_en     = 1'b1;
                        mem_wr_addr   = to_index(CW'(pos_reg));
                        mem_wr_size   = split_ok ? SZ_W'(need_w) : mem_rd_size;
                        mem_wr_free   = 1'b0;
                        rem_size_next = SZ_W'(CW'(mem_rd_size) - need_w - HDR_C);
                        status_next   = STATUS_ALLOC_OK;
                        addr_next     = pay_pos[OFFSET_W-1:0];
                        state_next    = split_ok ? FSM_SPLIT : FSM_RESP;
                    end else if (at_end) begin
                        status_next = STATUS_ALLOC_FAIL;
                        state_next  = FSM_RESP;
                    end else begin
                        pos_next    = POS_W'(hdr_end);
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = to_index(hdr_end);
                    end
                end else begin
                    if (pay_pos == CW'(target_reg)) begin
                        own_size_next = mem_rd_size;
                        if (at_end) begin
                            succ_free_next = 1'b0;
                            succ_size_next = '0;
                            state_next     = FSM_MERGE;
                        end else begin
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = to_index(hdr_end);
                            state_next  = FSM_PEEK;
                        end
                    end else if (at_end || (pay_pos > CW'(target_reg))) begin
                        status_next = STATUS_NOT_FOUND;
                        state_next  = FSM_RESP;
                    end else begin
                        prev_pos_next   = pos_reg;
                        prev_size_next  = mem_rd_size;
                        prev_free_next  = mem_rd_free;
                        prev_valid_next = 1'b1;
                        pos_next        = POS_W'(hdr_end);
                        mem_rd_en       = 1'b1;
                        mem_rd_addr     = to_index(hdr_end);
                    end
                end
            end

            // Capture the block after the one being released
            FSM_PEEK: begin
                succ_free_next = mem_rd_free;
                succ_size_next = mem_rd_size;
                state_next     = FSM_MERGE;
            end

            // Mark free and fold in free neighbors with one header write
            FSM_MERGE: begin
                mem_wr_en   = 1'b1;
                mem_wr_free = 1'b1;
                if (prev_valid_reg && prev_free_reg) begin
                    mem_wr_addr = to_index(CW'(prev_pos_reg));
                    mem_wr_size = SZ_W'(prev_merged);
                end else begin
                    mem_wr_addr = to_index(CW'(pos_reg));
                    mem_wr_size = SZ_W'(own_merged);
                end
                status_next = STATUS_FREED;
                addr_next   = '0;
                state_next  = FSM_RESP;
            end

            // Header of the free remainder after a split
            FSM_SPLIT: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = to_index(rem_pos);
                mem_wr_size = rem_size_reg;
                mem_wr_free = 1'b1;
                state_next  = FSM_RESP;
            end

            // Hand the response over once the output register is free
            FSM_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_status_next  = status_reg;
                    m_address_next = (status_reg == STATUS_ALLOC_OK) ? addr_reg : '0;
                    state_next     = FSM_IDLE;
                end
            end

            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= FSM_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        func_reg       <= func_next;
        target_reg     <= target_next;
        x_reg          <= x_next;
        q_reg          <= q_next;
        need_reg       <= need_next;
        pos_reg        <= pos_next;
        prev_pos_reg   <= prev_pos_next;
        prev_size_reg  <= prev_size_next;
        prev_free_reg  <= prev_free_next;
        prev_valid_reg <= prev_valid_next;
        own_size_reg   <= own_size_next;
        succ_size_reg  <= succ_size_next;
        succ_free_reg  <= succ_free_next;
        rem_size_reg   <= rem_size_next;
        status_reg     <= status_next;
        addr_reg       <= addr_next;
        m_status_reg   <= m_status_next;
        m_address_reg  <= m_address_next;
    end

    // Checks
    `FFBA_ASSERT_SAME(a_no_rw_overlap, aclk, aresetn, mem_wr_en, !mem_rd_en, "header read and write in one cycle")
    `FFBA_ASSERT_SAME(a_walk_in_arena, aclk, aresetn, state_reg == FSM_WALK, pos_reg < POS_W'(ARENA_BYTES), "walk left the arena")
    `FFBA_ASSERT_SAME(a_resp_source, aclk, aresetn, $rose(m_valid_reg), $past(state_reg) == FSM_RESP, "response raised outside response state")
    `FFBA_ASSERT_NEXT(a_zero_size_fails, aclk, aresetn, s_valid && s_ready && (s_func == FUNC_ALLOC) && (s_req_size == '0), (state_reg == FSM_RESP) && (status_reg == STATUS_ALLOC_FAIL), "zero size not rejected")

endmodule

`default_nettype wire

// File: rtl/core/ffba_hdr_mem.sv
`default_nettype none

module ffba_hdr_mem #(
    parameter int DEPTH      = ffba_pkg::HDR_DEPTH_DEF,
    parameter int ADDR_W     = ffba_pkg::HDR_ADDR_W_DEF,
    parameter int SIZE_W     = ffba_pkg::SIZE_W_DEF,
    parameter int RESET_SIZE = ffba_pkg::ARENA_BYTES_DEF - ffba_pkg::HEADER_BYTES_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [SIZE_W-1:0] rd_size,
    output logic                   rd_free,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [SIZE_W-1:0] wr_size,
    input  wire logic              wr_free
);

    // Header word: free mark on top, payload size below
    logic [SIZE_W:0] hdr_mem [DEPTH];
    logic [SIZE_W:0] rd_data_reg;
    logic            zero_written_reg;
    logic            rd_dflt_reg;

    // Single write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            hdr_mem[wr_addr] <= {wr_free, wr_size};
        end
        if (rd_en) begin
            rd_data_reg <= hdr_mem[rd_addr];
        end
    end

    // Entry zero reads as one free block spanning the arena until first written
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_written_reg <= 1'b0;
            rd_dflt_reg      <= 1'b0;
        end else begin
            if (wr_en && (wr_addr == '0)) begin
                zero_written_reg <= 1'b1;
            end
            if (rd_en) begin
                rd_dflt_reg <= (rd_addr == '0) && !zero_written_reg;
            end
        end
    end

    assign rd_size = rd_dflt_reg ? SIZE_W'(RESET_SIZE) : rd_data_reg[SIZE_W-1:0];
    assign rd_free = rd_dflt_reg | rd_data_reg[SIZE_W];

endmodule

`default_nettype wire
